/* sv/sequence_gcd_macros.svh */
// ---------------------------------------------------------------------------
// sequence_gcd_macros.svh
// Assertion macros used by the sequence_gcd controller. Each use expects clk and
// arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef SEQUENCE_GCD_MACROS_SVH
`define SEQUENCE_GCD_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SGCD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define SGCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/sgcd_pkg.sv */
// ---------------------------------------------------------------------------
// sgcd_pkg
// Types and constants shared by the running-GCD block.
// ---------------------------------------------------------------------------
package sgcd_pkg;

	localparam int VALUE_BITS = 31;
	// Common power-of-two count never exceeds VALUE_BITS - 1
	localparam int SHIFT_BITS = $clog2(VALUE_BITS);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [SHIFT_BITS-1:0] shift_t;

	// Controller states, one-hot
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // take a new value against the running GCD
		logic step;    // one binary-GCD reduction step
		logic commit;  // store the finished GCD as the running value
		logic clear;   // end of sequence: running value back to zero
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic done;    // reduction finished, result valid
	} dp_stat_t;

endpackage

/* sv/sgcd_in_if.sv */
// ---------------------------------------------------------------------------
// sgcd_in_if
// Input channel: one sequence value and its end-of-sequence flag per item.
// ---------------------------------------------------------------------------
interface sgcd_in_if import sgcd_pkg::*; ();

	logic   valid;
	logic   ready;
	value_t value;
	logic   is_last;

	modport source (output valid, output value, output is_last, input ready);
	modport sink   (input valid, input value, input is_last, output ready);

endinterface

/* sv/sgcd_out_if.sv */
// ---------------------------------------------------------------------------
// sgcd_out_if
// Output channel: one GCD per completed sequence.
// ---------------------------------------------------------------------------
interface sgcd_out_if import sgcd_pkg::*; ();

	logic   valid;
	logic   ready;
	value_t gcd;

	modport source (output valid, output gcd, input ready);
	modport sink   (input valid, input gcd, output ready);

endinterface

/* sv/sgcd_datapath.sv */
// ---------------------------------------------------------------------------
// sgcd_datapath
// Binary GCD engine plus the running-GCD register. At most one subtract and
// halve per step; the common power of two is counted and restored at the end.
// ---------------------------------------------------------------------------
module sgcd_datapath import sgcd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_cmd_t  cmd,
	input  value_t   value,
	output dp_stat_t stat,
	output value_t   result
);

	value_t run_q;
	value_t a_q;
	value_t b_q;
	shift_t k_q;

	logic [VALUE_BITS:0] diff_ab;
	value_t              diff_ba;
	value_t              base;

	// Termination: equal operands or one of them zero
	always_comb begin
		diff_ab   = {1'b0, a_q} - {1'b0, b_q};
		diff_ba   = b_q - a_q;
		stat.done = (a_q == b_q) || (a_q == '0) || (b_q == '0);
		base      = (a_q == '0) ? b_q : a_q;
		result    = base << k_q;
	end

	// Running GCD; zero means nothing folded in yet, and gcd(0, v) = v
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (cmd.clear) begin
			run_q <= '0;
		end else if (cmd.commit) begin
			run_q <= result;
		end
	end

	// Reduction registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= value;
			b_q <= run_q;
			k_q <= '0;
		end else if (cmd.step) begin
			priority if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + shift_t'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (!diff_ab[VALUE_BITS]) begin
				a_q <= diff_ab[VALUE_BITS-1:0] >> 1;
			end else begin
				b_q <= diff_ba >> 1;
			end
		end
	end

endmodule

/* sv/sgcd_ctrl.sv */
// ---------------------------------------------------------------------------
// sgcd_ctrl
// Sequencer for the GCD engine: loads an item, steps until done, then either
// keeps the result as the running value or hands it to the output register.
// ---------------------------------------------------------------------------
`include "sequence_gcd_macros.svh"

module sgcd_ctrl import sgcd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_is_last,
	output logic     in_ready,
	input  logic     out_free,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     emit
);

	state_t state_q;
	state_t state_d;
	logic   last_q;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		emit     = 1'b0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!stat.done) begin
					cmd.step = 1'b1;
				end else if (!last_q) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end else if (out_free) begin
					cmd.clear = 1'b1;
					emit      = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				last_q <= in_is_last;
			end
		end
	end

	// Checks
	`SGCD_ASSERT_NEXT(a_load_runs, cmd.load, state_q == ST_RUN, "load did not start a run")
	`SGCD_ASSERT_SAME(a_emit_last, emit, stat.done && last_q && out_free, "emit without finished last item")
	`SGCD_ASSERT_SAME(a_step_idle, state_q == ST_IDLE, !cmd.step && !cmd.commit && !emit, "datapath driven while idle")
	`SGCD_ASSERT_SAME(a_commit_mid, cmd.commit, !last_q && !cmd.clear, "commit on last item")

endmodule

/* sv/sequence_gcd.sv */
// Items are handled one at a time; the next item is accepted in the cycle
//   after the previous one finishes. A last item finishes only once the
//   output register is free; its result is registered and shown in the
//   cycle after it finishes.
// Reset (arst_n low, asynchronous) clears the running GCD and the output valid.
// ---------------------------------------------------------------------------
// sequence_gcd
// Running greatest common divisor over sequences of values, one GCD out per
// sequence on its last item.
// ---------------------------------------------------------------------------
module sequence_gcd import sgcd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	sgcd_in_if.sink    values,
	sgcd_out_if.source results
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	value_t   result;
	logic     emit;
	logic     out_free;
	logic     out_valid_q;
	value_t   out_gcd_q;

	assign out_free = !out_valid_q || results.ready;

	sgcd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (values.valid),
		.in_is_last (values.is_last),
		.in_ready   (values.ready),
		.out_free   (out_free),
		.stat       (stat),
		.cmd        (cmd),
		.emit       (emit)
	);

	sgcd_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.value  (values.value),
		.stat   (stat),
		.result (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_gcd_q <= result;
		end
	end

	assign results.valid = out_valid_q;
	assign results.gcd   = out_gcd_q;

endmodule

/* tb/sequence_gcd_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sequence_gcd_checker
// Watches both channels of the running-GCD block. Folds every accepted value
// into its own running GCD with the remainder loop, queues the GCD of
// each finished sequence and compares it with the next result item.
// ---------------------------------------------------------------------------
module sequence_gcd_checker import sgcd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	sgcd_in_if   values,
	sgcd_out_if  results,
	output int   mismatches,
	output int   pending
);

	value_t running_gcd;
	bit     seen_first;
	value_t expected_gcds[$];

	// Remainder loop; a zero operand gives the other one
	function automatic value_t remainder_gcd(value_t a, value_t b);
		value_t r;
		if (b == '0)
			return a;
		r = a % b;
		while (r != '0) begin
			a = b;
			b = r;
			r = a % b;
		end
		return b;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		value_t oldest_gcd;
		if (!arst_n) begin
			running_gcd = '0;
			seen_first  = 1'b0;
			expected_gcds.delete();
			mismatches  = 0;
			pending     = 0;
		end else begin
			// result side first: a result never belongs to this edge's item
			if (results.valid && results.ready) begin
				if (expected_gcds.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("gcd %0d arrived with no finished sequence waiting",
							results.gcd);
				end else begin
					oldest_gcd = expected_gcds.pop_front();
					if (results.gcd !== oldest_gcd) begin
						mismatches++;
						if (mismatches <= 10)
							$display("gcd mismatch: expected %0d, got %0d",
								oldest_gcd, results.gcd);
					end
				end
			end

			// fold the accepted item into the running GCD
			if (values.valid && values.ready) begin
				if (!seen_first) begin
					running_gcd = values.value;
					seen_first  = 1'b1;
				end else begin
					running_gcd = remainder_gcd(values.value, running_gcd);
				end
				if (values.is_last) begin
					expected_gcds.push_back(running_gcd);
					running_gcd = '0;
					seen_first  = 1'b0;
				end
			end

			pending = expected_gcds.size();
		end
	end

endmodule

/* tb/sequence_gcd_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sequence_gcd_tb
// Drives sequences of values into the running-GCD block: edge cases first,
// then random sequences built around common factors, with gaps and stalls
// on both channels and one long hold-off at the output. The checker beside
// the block does the comparison; this module gives the verdict.
// ---------------------------------------------------------------------------
module sequence_gcd_tb;
	import sgcd_pkg::*;

	localparam int     ITEM_TARGET = 1250;
	localparam int     HOLD_CYCLES = 300;
	localparam int     CYCLE_LIMIT = 400_000;
	localparam value_t VALUE_MAX   = '1;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   gaps_on;
	bit   stalls_on;
	bit   long_hold;
	bit   hold_served;
	int   items_sent;
	int   cycle_count;
	int   mismatches;
	int   pending;

	sgcd_in_if  values ();
	sgcd_out_if results ();

	sequence_gcd i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.values  (values),
		.results (results)
	);

	sequence_gcd_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.values     (values),
		.results    (results),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #6 clk = ~clk;

	// runaway guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sequence_gcd regression: fail");
			$finish;
		end
	end

	// result side: short random stalls, plus one long hold-off on request
	always begin
		@(negedge clk);
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else if (long_hold && !hold_served) begin
			results.ready <= 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_served = 1'b1;
			results.ready <= 1'b1;
		end else if (stalls_on && $urandom_range(0, 5) == 0) begin
			results.ready <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
			results.ready <= 1'b1;
		end else begin
			results.ready <= 1'b1;
		end
	end

	// offer one item and hold it until the block takes it
	task automatic send_value(value_t v, logic last);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			values.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		values.valid   <= 1'b1;
		values.value   <= v;
		values.is_last <= last;
		@(posedge clk);
		while (!values.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// one sequence, mostly multiples of a shared factor so the GCD is not trivial
	task automatic send_random_sequence();
		int unsigned base;
		int unsigned len;
		int unsigned pick;
		value_t      v;
		len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
		base = $urandom_range(1, 1 << $urandom_range(0, 24));
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				v = '0;
			else if (pick <= 2)
				v = value_t'($urandom);
			else if (pick == 3)
				v = value_t'($urandom_range(1, 64));
			else if (pick == 4)
				v = value_t'(base << $urandom_range(0, 6));
			else
				v = value_t'(base * $urandom_range(1, VALUE_MAX / base));
			send_value(v, i == len - 1);
		end
	endtask

	initial begin
		bit hold_done;
		values.valid   = 1'b0;
		values.value   = '0;
		values.is_last = 1'b0;
		hold_done      = 1'b0;
		gaps_on        = 1'b1;
		stalls_on      = 1'b1;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// single-item sequences: largest, smallest, zero
		send_value(VALUE_MAX, 1'b1);
		send_value(31'd1, 1'b1);
		send_value('0, 1'b1);
		// zero first, zero in the middle, all zero
		send_value('0, 1'b0);
		send_value(31'd12, 1'b0);
		send_value(31'd18, 1'b1);
		send_value(31'd12, 1'b0);
		send_value('0, 1'b0);
		send_value(31'd18, 1'b1);
		send_value('0, 1'b0);
		send_value('0, 1'b1);
		// neighbouring terms of the golden-ratio sequence: longest remainder chain
		send_value(31'd1836311903, 1'b0);
		send_value(31'd1134903170, 1'b1);
		// shared power of two
		send_value(31'h4000_0000, 1'b0);
		send_value(31'h0030_0000, 1'b1);
		// alternating bit patterns
		send_value(31'h5555_5555, 1'b0);
		send_value(31'h2AAA_AAAA, 1'b1);
		// top values, coprime neighbours
		send_value(VALUE_MAX, 1'b0);
		send_value(value_t'(VALUE_MAX - 1), 1'b0);
		send_value(31'h4000_0000, 1'b1);

		// random sequences; block fills while the output is held off
		while (items_sent < ITEM_TARGET) begin
			gaps_on   = (items_sent < 400) || (items_sent >= 500 && items_sent < 1000);
			stalls_on = items_sent < 1000;
			if (items_sent >= 400 && !hold_done) begin
				long_hold = 1'b1;
				hold_done = 1'b1;
			end
			send_random_sequence();
		end
		@(negedge clk);
		values.valid <= 1'b0;

		// drain, then allow for one more full reduction
		while (pending != 0)
			@(negedge clk);
		repeat (2 * VALUE_BITS + 4) @(negedge clk);

		if (mismatches == 0 && pending == 0)
			$display("sequence_gcd regression: pass");
		else
			$display("sequence_gcd regression: fail");
		$finish;
	end

endmodule

/* sequence_gcd.f */
+incdir+sv
sv/sgcd_pkg.sv
sv/sgcd_in_if.sv
sv/sgcd_out_if.sv
sv/sgcd_datapath.sv
sv/sgcd_ctrl.sv
sv/sequence_gcd.sv
tb/sequence_gcd_checker.sv
tb/sequence_gcd_tb.sv
